// ===== rtl/zsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsq_pkg
// shared constants and types of the z-score dual range quantizer
// ----------------------------------------------------------------------------
package zsq_pkg;
	localparam int BLOCK_ITEMS  = 2048;
	localparam int SAMPLE_ITEMS = 16;
	localparam int WIN = (SAMPLE_ITEMS < BLOCK_ITEMS) ? SAMPLE_ITEMS : BLOCK_ITEMS;
	localparam int WIN_W = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int POS_W = $clog2(BLOCK_ITEMS);
	localparam int SUM_W = 24 + WIN_W + 1;
	localparam int SQ_W  = 48 + WIN_W + 1;

	localparam logic [2:0] CFG_USE_FIXED = 3'd0;
	localparam logic [2:0] CFG_MEAN      = 3'd1;
	localparam logic [2:0] CFG_INV_STD   = 3'd2;
	localparam logic [2:0] CFG_SHIFT     = 3'd3;
	localparam logic [2:0] CFG_SCALE     = 3'd4;

	// one queued job for the back part, with the statistics it is normalised by
	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] mean;
		logic [23:0]        inv;
		logic               last_blk;
		logic               last_run;
	} job_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
endpackage

// ===== rtl/zsq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsq_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
module zsq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/zsq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsq_front
// accepts items, in sampled mode buffers the window and computes statistics, issues jobs
// ----------------------------------------------------------------------------
module zsq_front import zsq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample,
	input  logic               use_fixed,
	input  logic signed [23:0] fixed_mean,
	input  logic [23:0]        fixed_inv,
	output logic               job_valid,
	input  logic               job_full,
	output job_t               job
);
	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_VAR = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]              state_q;
	logic [POS_W-1:0]        pos_q;
	logic                    mode_q;
	logic                    lastblk_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic signed [23:0]      mean_q;
	logic [23:0]             inv_q;
	logic [63:0]             var_q;
	logic [4:0]              bit_q;
	logic [23:0]             root_q;
	logic [95:0]             s_q;
	logic [95:0]             a_q;
	logic [95:0]             u_q;
	logic [WIN_W:0]          fl_q;
	logic                    rd_pend_q;
	logic [WIN_W-1:0]        fl_idx_q;
	logic                    fl_last_q;
	logic [23:0]             rdata;

	logic        acc;
	logic        cur_fixed;
	logic        in_win;
	logic        last_blk;
	logic [WIN_W-1:0] waddr;
	logic [SUM_W-1:0] abs_sum;
	logic [2*SUM_W-1:0] sum_sq;
	logic [SQ_W+WIN_W:0] wsq;
	logic [63:0] var_n;
	logic [95:0] cand_s;
	logic        take;
	logic        rd_go;
	logic signed [47:0] xx;

	assign cur_fixed = (pos_q == '0) ? use_fixed : mode_q;
	assign in_win = !cur_fixed && ({{(32-POS_W){1'b0}}, pos_q} < WIN);
	assign last_blk = ({{(32-POS_W){1'b0}}, pos_q} == BLOCK_ITEMS - 1);
	assign in_stall = (state_q != ST_RUN) || (!in_win && job_full);
	assign acc = in_valid && !in_stall;
	assign waddr = pos_q[WIN_W-1:0];
	assign xx = sample * sample;

	zsq_ram #(.WIDTH(24), .DEPTH(WIN)) u_buf (
		.clk(clk), .we(acc && in_win), .waddr(waddr), .wdata(sample),
		.raddr(fl_idx_q), .rdata(rdata)
	);

	assign abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign sum_sq = abs_sum * abs_sum;
	assign wsq = (SQ_W+WIN_W+1)'(sq_q) * (SQ_W+WIN_W+1)'(WIN);
	assign var_n = (wsq > (SQ_W+WIN_W+1)'(sum_sq)) ?
		64'((wsq - (SQ_W+WIN_W+1)'(sum_sq)) / (WIN * WIN)) : 64'd0;
	// q*q*v of the candidate from running sums, no multiplier
	assign cand_s = s_q + u_q + a_q;
	assign take = (cand_s <= 96'h1_0000_0000_0000_0000);
	assign rd_go = (state_q == ST_FLUSH) && (fl_q != '0) && !job_full;

	always_comb begin
		job_valid = 1'b0;
		job.x = sample;
		job.mean = (pos_q == '0) ? fixed_mean : mean_q;
		job.inv = (pos_q == '0) ? fixed_inv : inv_q;
		job.last_blk = last_blk;
		job.last_run = 1'b1;
		if (state_q == ST_RUN) begin
			job_valid = acc && !in_win;
		end
		if (rd_pend_q) begin
			job_valid = 1'b1;
			job.x = rdata;
			job.mean = mean_q;
			job.inv = inv_q;
			job.last_blk = fl_last_q && lastblk_q;
			job.last_run = fl_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			pos_q <= '0;
			mode_q <= 1'b0;
			lastblk_q <= 1'b0;
			sum_q <= '0;
			sq_q <= '0;
			mean_q <= '0;
			inv_q <= '0;
			fl_q <= '0;
			rd_pend_q <= 1'b0;
			fl_idx_q <= '0;
			fl_last_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_go;
			case (state_q)
				ST_RUN: begin
					if (acc) begin
						pos_q <= last_blk ? '0 : pos_q + 1'b1;
						if (pos_q == '0) begin
							mode_q <= use_fixed;
							if (use_fixed) begin
								mean_q <= fixed_mean;
								inv_q <= fixed_inv;
							end
						end
						if (in_win) begin
							sum_q <= (pos_q == '0 ? '0 : sum_q) + SUM_W'(sample);
							sq_q <= (pos_q == '0 ? '0 : sq_q) + SQ_W'(unsigned'(xx));
							if ({{(32-POS_W){1'b0}}, pos_q} == WIN - 1) begin
								state_q <= ST_VAR;
								lastblk_q <= last_blk;
							end
						end
					end
				end
				ST_VAR: begin
					mean_q <= 24'(sum_q / SUM_W'(WIN));
					var_q <= var_n;
					root_q <= '0;
					s_q <= '0;
					u_q <= '0;
					a_q <= 96'(var_n) << 46;
					bit_q <= 5'd23;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (var_q <= 64'd1) begin
						inv_q <= 24'hFFFFFF;
						state_q <= ST_FLUSH;
						fl_q <= (WIN_W+1)'(WIN);
						fl_idx_q <= '0;
					end else begin
						if (take) begin
							root_q <= root_q | (24'd1 << bit_q);
							s_q <= cand_s;
							u_q <= (u_q >> 1) + a_q;
						end else begin
							u_q <= u_q >> 1;
						end
						a_q <= a_q >> 2;
						if (bit_q == 5'd0) begin
							inv_q <= take ? (root_q | (24'd1 << bit_q)) : root_q;
							state_q <= ST_FLUSH;
							fl_q <= (WIN_W+1)'(WIN);
							fl_idx_q <= '0;
						end
						bit_q <= bit_q - 5'd1;
					end
				end
				ST_FLUSH: begin
					if (rd_go) begin
						fl_q <= fl_q - 1'b1;
						fl_last_q <= (fl_q == (WIN_W+1)'(1));
						fl_idx_q <= fl_idx_q + 1'b1;
					end else if (fl_q == '0 && !rd_pend_q) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule

// ===== rtl/zsq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsq_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module zsq_queue import zsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output job_t dout
);
	job_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	// two slots kept in hand so a flush read in flight always fits
	assign full = (cnt_q >= (QPTR_W+1)'(QDEPTH - 2));
	assign pop_valid = (cnt_q != '0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end
endmodule

// ===== rtl/zsq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsq_back
// normalising and quantising pipeline with output register
// ----------------------------------------------------------------------------
module zsq_back import zsq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_pop,
	input  job_t               job,
	input  logic signed [23:0] scale,
	input  logic signed [23:0] shift,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] code,
	output logic               last_of_block,
	output logic               last_of_run
);
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [1:0]        t_s1, t_s2, t_s3, t_s4;
	logic signed [49:0] p_s1;
	logic signed [67:0] n_s2;
	logic signed [67:0] m_s3;
	logic              nar_s3;
	logic signed [16:0] c_s4;
	logic              adv;

	logic signed [24:0] d;
	logic signed [33:0] z;
	logic signed [57:0] zs;
	logic signed [67:0] nn;
	logic              nar;
	logic signed [67:0] mag;
	logic [67:0]       am;
	logic [15:0]       qa;
	logic signed [31:0] q;

	assign adv = !(v_s4 && out_stall);
	assign job_pop = job_valid && adv;
	assign d = 25'(job.x) - 25'(job.mean);
	assign z = 34'(p_s1 >>> 16);
	assign zs = z * scale;
	assign nn = 68'(zs >>> 16) + 68'(shift);
	assign nar = (n_s2 >= -68'sd65536) && (n_s2 <= 68'sd65536);
	assign mag = n_s2 <<< (nar ? 5 : 7);
	assign am = m_s3[67] ? 68'(-m_s3) : 68'(m_s3);
	// divide by 196608: shift by 16 then divide by 3 via reciprocal, capped early
	always_comb begin
		logic [67:0] t;
		logic [33:0] pr;
		t = am >> 16;
		pr = 34'(t[16:0]) * 34'd43691;
		if (t > 68'd98301)
			qa = 16'd32767;
		else
			qa = 16'(pr >> 17);
		q = m_s3[67] ? -32'(qa) : 32'(qa);
	end

	assign out_valid = v_s4;
	assign code = c_s4;
	assign last_of_block = t_s4[1];
	assign last_of_run = t_s4[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= d * $signed({1'b0, job.inv});
			t_s1 <= {job.last_blk, job.last_run};
			n_s2 <= nn;
			t_s2 <= t_s1;
			m_s3 <= mag;
			nar_s3 <= nar;
			t_s3 <= t_s2;
			c_s4 <= {q[15:0], nar_s3};
			t_s4 <= t_s3;
		end
	end
endmodule

// ===== rtl/zscore_dual_scale_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_dual_scale_quantizer
// z-score normalisation with dual range quantisation of sample blocks
// ----------------------------------------------------------------------------
// samples come in on in_valid/in_stall, codes leave on out_valid/out_stall
// configuration is written on cfg_we/cfg_index/cfg_data while nothing is in flight
// an item outside the window goes through the queue and the four back
// stages before it is offered; such items follow one a cycle unless stalled
// in sampled mode the first window of each block is buffered; after its last
// item the front computes mean and variance and runs the bitwise root search,
// then flushes the window one item a cycle while the queue has room; the input
// is held from the last window item until the flush is done
// the statistics travel with each item through the queue
// a small queue decouples the front from the back, so a stalled receiver
// freezes the four stage back pipeline, fills the queue and then holds the input
// reset clears all control state and loads the register reset values
// ----------------------------------------------------------------------------
module zscore_dual_scale_quantizer import zsq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] code,
	output logic               last_of_block,
	output logic               last_of_run,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	logic               use_fixed_q;
	logic signed [23:0] fmean_q, shift_q, scale_q;
	logic [23:0]        finv_q;
	logic               jv, jfull, qv, qpop;
	job_t               jin, jout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_fixed_q <= 1'b0;
			fmean_q <= '0;
			finv_q <= 24'd65536;
			shift_q <= '0;
			scale_q <= 24'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_USE_FIXED: use_fixed_q <= cfg_data[0];
				CFG_MEAN:      fmean_q <= cfg_data;
				CFG_INV_STD:   finv_q <= cfg_data;
				CFG_SHIFT:     shift_q <= cfg_data;
				CFG_SCALE:     scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	zsq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .use_fixed(use_fixed_q), .fixed_mean(fmean_q),
		.fixed_inv(finv_q), .job_valid(jv), .job_full(jfull), .job(jin)
	);

	zsq_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(jv), .din(jin), .full(jfull),
		.pop_valid(qv), .pop(qpop), .dout(jout)
	);

	zsq_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qv), .job_pop(qpop), .job(jout),
		.scale(scale_q), .shift(shift_q),
		.out_valid(out_valid), .out_stall(out_stall), .code(code),
		.last_of_block(last_of_block), .last_of_run(last_of_run)
	);
endmodule
